// ----- hw/rtl/bbe_pkg.sv -----
`timescale 1ns / 1ps
// Package for the bit set bank engine: sizes, action codes, state type and
// the per-word valid mask. No dependencies.
package bbe_pkg;

  localparam int MAX_BITS      = 1024;
  localparam int NUM_SETS      = 8;
  localparam int WORD_BITS     = 64;
  localparam int WORDS_PER_SET = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int BANK_WORDS    = NUM_SETS * WORDS_PER_SET;

  localparam int SLOT_W  = $clog2(NUM_SETS);
  localparam int WIDX_W  = $clog2(WORDS_PER_SET);
  localparam int ADDR_W  = SLOT_W + WIDX_W;
  localparam int BOFS_W  = $clog2(WORD_BITS);
  localparam int CNT_W   = $clog2(WORDS_PER_SET + 1);
  localparam int LEN_W   = 11;
  localparam int BIT_W   = 10;
  localparam int SET_W   = 3;
  localparam int ACT_W   = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_SET    = 3'd1,
    ACT_TEST   = 3'd2,
    ACT_UNION  = 3'd3,
    ACT_DISJ   = 3'd4,
    ACT_PREFIX = 3'd5
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Valid bits of word w of a set that is len bits long.
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [WIDX_W-1:0] w,
                                                     input logic [LEN_W-1:0]  len);
    logic [LEN_W-BOFS_W-1:0] hi;
    logic [WORD_BITS-1:0]    m;
    hi = len[LEN_W-1:BOFS_W];
    if (hi > (LEN_W-BOFS_W)'(w)) begin
      m = '1;
    end else if (hi == (LEN_W-BOFS_W)'(w)) begin
      m = (WORD_BITS'(1) << len[BOFS_W-1:0]) - WORD_BITS'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/bitset_bank_engine.sv -----
`timescale 1ns / 1ps
// Bit set bank engine top level: word store, valid bits and word walker.
// Depends on bbe_pkg.

// A bank of 8 bit sets of up to 1024 bits each, kept as 64-bit words in a
// 128-word memory with two registered read ports and one write port. Issue a
// request by raising start while busy is low; the request transfers on that
// clock edge. Exactly one result per request shows on out_status/out_flag for
// a single cycle with out_strobe high; there is no way to hold it off, so the
// receiver must take it on that edge. Clear, unused actions, out of range
// requests and walks of zero words answer on the cycle after the transfer
// (busy never rises). Set bit and test bit read one word; the answer comes
// through the registered memory read and then the output register. Union
// and intersection-empty walk N = ceil(length / 64) words, prefix-full walks
// N = ceil(prefix_length / 64) words, N at most 16, one read per cycle
// through the memory pipeline; each word is processed once its registered
// read returns, and busy stays high until the last word is processed.
// Reset clears the store through one valid bit per word, so there is no
// clearing pass; clear of a slot drops its 16 valid bits at once.
// User must write set_length through cfg_we/cfg_wdata only while no request
// is in flight; the block does not enforce this. Values above 1024 act as 1024.
module bitset_bank_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bbe_pkg::LEN_W-1:0]  cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic [bbe_pkg::ACT_W-1:0]  in_action,
  input  logic [bbe_pkg::SET_W-1:0]  in_first_set,
  input  logic [bbe_pkg::SET_W-1:0]  in_second_set,
  input  logic [bbe_pkg::BIT_W-1:0]  in_bit_index,
  input  logic [bbe_pkg::LEN_W-1:0]  in_prefix_length,
  output logic                       out_strobe,
  output logic                       out_status,
  output logic                       out_flag
);

  localparam int WB = bbe_pkg::WORD_BITS;

  // Word store; valid_r marks words written since reset or last clear.
  logic [WB-1:0]                  mem [bbe_pkg::BANK_WORDS];
  logic [bbe_pkg::BANK_WORDS-1:0] valid_r;

  logic [bbe_pkg::LEN_W-1:0] set_length_r;

  bbe_pkg::state_t state_r, state_nxt;

  // Request held for the walk
  bbe_pkg::act_t               act_r, act_nxt;
  logic [bbe_pkg::SLOT_W-1:0]  slot_a_r, slot_a_nxt;
  logic [bbe_pkg::SLOT_W-1:0]  slot_b_r, slot_b_nxt;
  logic [bbe_pkg::BOFS_W-1:0]  bofs_r, bofs_nxt;
  logic [bbe_pkg::WIDX_W-1:0]  wbase_r, wbase_nxt;
  logic [bbe_pkg::LEN_W-1:0]   mlen_r, mlen_nxt;
  logic [bbe_pkg::CNT_W-1:0]   nw_r, nw_nxt;
  logic [bbe_pkg::CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic                        flag_r, flag_nxt;

  // Read pipeline stage
  logic                        p_vld_r, p_vld_nxt;
  logic                        p_last_r, p_last_nxt;
  logic [bbe_pkg::WIDX_W-1:0]  p_w_r, p_w_nxt;
  logic [WB-1:0]               rd_a_r, rd_b_r;
  logic                        va_r, vb_r;

  logic out_strobe_r, out_strobe_nxt;
  logic out_status_r, out_status_nxt;
  logic out_flag_r, out_flag_nxt;

  // Memory access controls
  logic                        rd_en;
  logic [bbe_pkg::WIDX_W-1:0]  rd_w;
  logic [bbe_pkg::ADDR_W-1:0]  rd_addr_a, rd_addr_b;
  logic                        mem_we;
  logic [bbe_pkg::ADDR_W-1:0]  mem_waddr;
  logic [WB-1:0]               mem_wdata;
  logic                        clr_en;
  logic [bbe_pkg::SLOT_W-1:0]  clr_slot;

  // Transfer-cycle decode
  logic                        accept;
  bbe_pkg::act_t               in_act;
  logic [bbe_pkg::LEN_W-1:0]   len_eff;
  logic                        oor_bit, oor_plen;
  logic [bbe_pkg::LEN_W-1:0]   in_mlen;
  logic [bbe_pkg::LEN_W:0]     nw_sum;
  logic [bbe_pkg::CNT_W-1:0]   in_nw;

  // Word processing
  logic [WB-1:0] wa, wb, wm, bm, union_w;

  assign busy       = (state_r != bbe_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_status = out_status_r;
  assign out_flag   = out_flag_r;

  assign accept  = start && (state_r == bbe_pkg::ST_IDLE);
  assign in_act  = bbe_pkg::act_t'(in_action);
  assign len_eff = (set_length_r > bbe_pkg::LEN_W'(bbe_pkg::MAX_BITS)) ?
                   bbe_pkg::LEN_W'(bbe_pkg::MAX_BITS) : set_length_r;
  assign oor_bit  = {1'b0, in_bit_index} >= len_eff;
  assign oor_plen = in_prefix_length > len_eff;
  assign in_mlen  = (in_act == bbe_pkg::ACT_PREFIX) ? in_prefix_length : len_eff;
  assign nw_sum   = {1'b0, in_mlen} + (bbe_pkg::LEN_W+1)'(WB - 1);
  assign in_nw    = nw_sum[bbe_pkg::BOFS_W +: bbe_pkg::CNT_W];

  // Unwritten words read as zero
  assign wa = va_r ? rd_a_r : '0;
  assign wb = vb_r ? rd_b_r : '0;
  assign wm = bbe_pkg::word_mask(p_w_r, mlen_r);
  assign bm = WB'(1) << bofs_r;
  assign union_w = wa | (wb & wm);

  assign rd_w      = wbase_r + rd_cnt_r[bbe_pkg::WIDX_W-1:0];
  assign rd_addr_a = {slot_a_r, rd_w};
  assign rd_addr_b = {slot_b_r, rd_w};

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    slot_a_nxt     = slot_a_r;
    slot_b_nxt     = slot_b_r;
    bofs_nxt       = bofs_r;
    wbase_nxt      = wbase_r;
    mlen_nxt       = mlen_r;
    nw_nxt         = nw_r;
    rd_cnt_nxt     = rd_cnt_r;
    flag_nxt       = flag_r;
    p_vld_nxt      = 1'b0;
    p_last_nxt     = p_last_r;
    p_w_nxt        = p_w_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_flag_nxt   = out_flag_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = {slot_a_r, p_w_r};
    mem_wdata      = union_w;
    clr_en         = 1'b0;
    clr_slot       = in_first_set[bbe_pkg::SLOT_W-1:0];

    case (state_r)
      bbe_pkg::ST_IDLE: begin
        if (accept) begin
          act_nxt    = in_act;
          slot_a_nxt = in_first_set[bbe_pkg::SLOT_W-1:0];
          slot_b_nxt = in_second_set[bbe_pkg::SLOT_W-1:0];
          bofs_nxt   = in_bit_index[bbe_pkg::BOFS_W-1:0];
          mlen_nxt   = in_mlen;
          rd_cnt_nxt = '0;
          case (in_act)
            bbe_pkg::ACT_CLEAR: begin
              clr_en         = 1'b1;
              out_strobe_nxt = 1'b1;
              out_status_nxt = 1'b0;
              out_flag_nxt   = 1'b0;
            end
            bbe_pkg::ACT_SET, bbe_pkg::ACT_TEST: begin
              wbase_nxt = in_bit_index[bbe_pkg::BOFS_W +: bbe_pkg::WIDX_W];
              nw_nxt    = bbe_pkg::CNT_W'(1);
              flag_nxt  = 1'b0;
              if (oor_bit) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = 1'b1;
                out_flag_nxt   = 1'b0;
              end else begin
                state_nxt = bbe_pkg::ST_RUN;
              end
            end
            bbe_pkg::ACT_UNION, bbe_pkg::ACT_DISJ, bbe_pkg::ACT_PREFIX: begin
              wbase_nxt = '0;
              nw_nxt    = in_nw;
              flag_nxt  = (in_act != bbe_pkg::ACT_UNION);
              if (in_act == bbe_pkg::ACT_PREFIX && oor_plen) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = 1'b1;
                out_flag_nxt   = 1'b0;
              end else if (in_nw == '0) begin
                // empty walk: no change, empty, full
                out_strobe_nxt = 1'b1;
                out_status_nxt = 1'b0;
                out_flag_nxt   = (in_act != bbe_pkg::ACT_UNION);
              end else begin
                state_nxt = bbe_pkg::ST_RUN;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = 1'b0;
              out_flag_nxt   = 1'b0;
            end
          endcase
        end
      end

      bbe_pkg::ST_RUN: begin
        // issue side: one word read per cycle
        if (rd_cnt_r != nw_r) begin
          rd_en      = 1'b1;
          rd_cnt_nxt = rd_cnt_r + bbe_pkg::CNT_W'(1);
          p_vld_nxt  = 1'b1;
          p_w_nxt    = rd_w;
          p_last_nxt = (rd_cnt_r + bbe_pkg::CNT_W'(1)) == nw_r;
        end
        // process side: data of the word read last cycle
        if (p_vld_r) begin
          case (act_r)
            bbe_pkg::ACT_SET: begin
              flag_nxt  = (wa & bm) == '0;
              mem_we    = 1'b1;
              mem_wdata = wa | bm;
            end
            bbe_pkg::ACT_TEST: begin
              flag_nxt = (wa & bm) != '0;
            end
            bbe_pkg::ACT_UNION: begin
              if (union_w != wa) begin
                mem_we   = 1'b1;
                flag_nxt = 1'b1;
              end
            end
            bbe_pkg::ACT_DISJ: begin
              if ((wa & wb & wm) != '0) begin
                flag_nxt = 1'b0;
              end
            end
            bbe_pkg::ACT_PREFIX: begin
              if ((wa & wm) != wm) begin
                flag_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
          if (p_last_r) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = 1'b0;
            out_flag_nxt   = flag_nxt;
            state_nxt      = bbe_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = bbe_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bbe_pkg::ST_IDLE;
      set_length_r <= bbe_pkg::LEN_W'(bbe_pkg::MAX_BITS);
      rd_cnt_r     <= '0;
      p_vld_r      <= 1'b0;
      out_strobe_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      p_vld_r      <= p_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        set_length_r <= cfg_wdata;
      end
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (clr_en) begin
        for (int j = 0; j < bbe_pkg::WORDS_PER_SET; j++) begin
          valid_r[{clr_slot, bbe_pkg::WIDX_W'(j)}] <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    slot_a_r     <= slot_a_nxt;
    slot_b_r     <= slot_b_nxt;
    bofs_r       <= bofs_nxt;
    wbase_r      <= wbase_nxt;
    mlen_r       <= mlen_nxt;
    nw_r         <= nw_nxt;
    flag_r       <= flag_nxt;
    p_last_r     <= p_last_nxt;
    p_w_r        <= p_w_nxt;
    out_status_r <= out_status_nxt;
    out_flag_r   <= out_flag_nxt;
  end

  // Word memory: two registered reads, one write. Writes land on the word
  // read the cycle before, never on the word being read now.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
      va_r   <= valid_r[rd_addr_a];
      vb_r   <= valid_r[rd_addr_b];
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bitset_bank_engine: directed and random requests
// against a bank model kept in the bench. Depends on bbe_pkg and the engine RTL.
module testbench;

  // Action codes the engine decodes as no-ops.
  localparam logic [bbe_pkg::ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [bbe_pkg::ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  // Watchdog limit: cycles with neither a request nor a result transfer.
  // The slowest request walks 16 words; sender gaps are short.
  localparam int STALL_LIMIT = 5000;
  // Cycles to keep watching for stray results after the last expected one.
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic [bbe_pkg::ACT_W-1:0] action;
    logic [bbe_pkg::SET_W-1:0] first_set;
    logic [bbe_pkg::SET_W-1:0] second_set;
    logic [bbe_pkg::BIT_W-1:0] bit_pos;
    logic [bbe_pkg::LEN_W-1:0] pfx_len;
  } request_t;

  typedef struct packed {
    logic status;
    logic flag;
  } answer_t;

  // DUT connections; every input is known from time zero.
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [bbe_pkg::LEN_W-1:0] cfg_wdata = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [bbe_pkg::ACT_W-1:0] in_action = '0;
  logic [bbe_pkg::SET_W-1:0] in_first_set = '0;
  logic [bbe_pkg::SET_W-1:0] in_second_set = '0;
  logic [bbe_pkg::BIT_W-1:0] in_bit_index = '0;
  logic [bbe_pkg::LEN_W-1:0] in_prefix_length = '0;
  logic                      out_strobe;
  logic                      out_status;
  logic                      out_flag;

  bitset_bank_engine uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_first_set     (in_first_set),
    .in_second_set    (in_second_set),
    .in_bit_index     (in_bit_index),
    .in_prefix_length (in_prefix_length),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_flag         (out_flag)
  );

  // Bench copy of the store and the length register.
  logic [bbe_pkg::WORD_BITS-1:0] bank_words [bbe_pkg::NUM_SETS][bbe_pkg::WORDS_PER_SET];
  logic [bbe_pkg::LEN_W-1:0]     length_reg;

  request_t pending_q [$];   // requests waiting for the driver
  answer_t  answer_q  [$];   // predicted results, oldest first
  request_t cur_req;         // request currently presented on the in_ ports

  int sent_count    = 0;
  int checked_count = 0;
  int range_count   = 0;
  int flag_count    = 0;
  int phase_count   = 0;
  int fail_count    = 0;
  int stall_cycles  = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bank model
  // ---------------------------------------------------------------------------

  function automatic int live_length();
    return (int'(length_reg) > bbe_pkg::MAX_BITS) ? bbe_pkg::MAX_BITS : int'(length_reg);
  endfunction

  // Bits of word w that lie below len.
  function automatic logic [bbe_pkg::WORD_BITS-1:0] live_bits(int w, int len);
    int lo;
    int n;
    lo = w * bbe_pkg::WORD_BITS;
    if (len <= lo) return '0;
    n = len - lo;
    if (n >= bbe_pkg::WORD_BITS) return '1;
    return (bbe_pkg::WORD_BITS'(1) << n) - bbe_pkg::WORD_BITS'(1);
  endfunction

  // Apply one request to the bank copy and queue the answer it must produce.
  task automatic predict_answer(input request_t r);
    int                            len;
    int                            nwords;
    int                            a;
    int                            b;
    int                            w;
    int                            widx;
    logic [bbe_pkg::WORD_BITS-1:0] m;
    logic [bbe_pkg::WORD_BITS-1:0] merged;
    answer_t                       ans;
    len    = live_length();
    nwords = (len + bbe_pkg::WORD_BITS - 1) / bbe_pkg::WORD_BITS;
    a      = int'(r.first_set) % bbe_pkg::NUM_SETS;
    b      = int'(r.second_set) % bbe_pkg::NUM_SETS;
    ans    = '0;
    case (r.action)
      bbe_pkg::ACT_CLEAR: begin
        // wipes the whole slot, bits past the length too
        for (w = 0; w < bbe_pkg::WORDS_PER_SET; w++) bank_words[a][w] = '0;
      end
      bbe_pkg::ACT_SET, bbe_pkg::ACT_TEST: begin
        if (int'(r.bit_pos) >= len) begin
          ans.status = 1'b1;
        end else begin
          widx = int'(r.bit_pos) / bbe_pkg::WORD_BITS;
          m    = bbe_pkg::WORD_BITS'(1) << (int'(r.bit_pos) % bbe_pkg::WORD_BITS);
          if (r.action == bbe_pkg::ACT_SET) begin
            ans.flag = ((bank_words[a][widx] & m) == '0);
            bank_words[a][widx] = bank_words[a][widx] | m;
          end else begin
            ans.flag = ((bank_words[a][widx] & m) != '0);
          end
        end
      end
      bbe_pkg::ACT_UNION: begin
        // a == b is fine: each word is read before it is written
        for (w = 0; w < nwords; w++) begin
          merged = bank_words[a][w] | (bank_words[b][w] & live_bits(w, len));
          if (merged != bank_words[a][w]) begin
            bank_words[a][w] = merged;
            ans.flag = 1'b1;
          end
        end
      end
      bbe_pkg::ACT_DISJ: begin
        ans.flag = 1'b1;
        for (w = 0; w < nwords; w++) begin
          if ((bank_words[a][w] & bank_words[b][w] & live_bits(w, len)) != '0)
            ans.flag = 1'b0;
        end
      end
      bbe_pkg::ACT_PREFIX: begin
        if (int'(r.pfx_len) > len) begin
          ans.status = 1'b1;
        end else begin
          ans.flag = 1'b1;
          for (w = 0; w < (int'(r.pfx_len) + bbe_pkg::WORD_BITS - 1) / bbe_pkg::WORD_BITS;
               w++) begin
            m = live_bits(w, int'(r.pfx_len));
            if ((bank_words[a][w] & m) != m) ans.flag = 1'b0;
          end
        end
      end
      default: begin
        // unused codes: status 0, flag 0, store untouched
      end
    endcase
    if (ans.status) range_count++;
    if (ans.flag) flag_count++;
    answer_q.push_back(ans);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_request(input logic [bbe_pkg::ACT_W-1:0] act, input int a,
                               input int b, input int bpos, input int plen);
    request_t r;
    r.action     = act;
    r.first_set  = bbe_pkg::SET_W'(a);
    r.second_set = bbe_pkg::SET_W'(b);
    r.bit_pos    = bbe_pkg::BIT_W'(bpos);
    r.pfx_len    = bbe_pkg::LEN_W'(plen);
    pending_q.push_back(r);
  endtask

  // Random request shaped around the current length: most indexes in range,
  // some at the boundary, a few anywhere. Slots 0 and 1 are favored so that
  // bits pile up and prefix and intersection checks see dense sets.
  function automatic request_t random_request(int len);
    request_t r;
    int       pick;
    int       top;
    pick = $urandom_range(0, 99);
    if (pick < 3)       r.action = bbe_pkg::ACT_CLEAR;
    else if (pick < 28) r.action = bbe_pkg::ACT_SET;
    else if (pick < 46) r.action = bbe_pkg::ACT_TEST;
    else if (pick < 62) r.action = bbe_pkg::ACT_UNION;
    else if (pick < 77) r.action = bbe_pkg::ACT_DISJ;
    else if (pick < 95) r.action = bbe_pkg::ACT_PREFIX;
    else                r.action = ($urandom_range(0, 1) != 0) ? ACT_UNUSED_LO
                                                               : ACT_UNUSED_HI;
    r.first_set  = bbe_pkg::SET_W'(($urandom_range(0, 99) < 60) ? $urandom_range(0, 1)
                                                                : $urandom_range(0, 7));
    r.second_set = bbe_pkg::SET_W'(($urandom_range(0, 99) < 60) ? $urandom_range(0, 1)
                                                                : $urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 75 && len > 0) begin
      r.bit_pos = bbe_pkg::BIT_W'($urandom_range(0, len - 1));
    end else if (pick < 87) begin
      top = len - 1 + $urandom_range(0, 2);
      r.bit_pos = bbe_pkg::BIT_W'((top > 1023) ? 1023 : ((top < 0) ? 0 : top));
    end else begin
      r.bit_pos = bbe_pkg::BIT_W'($urandom_range(0, 1023));
    end
    pick = $urandom_range(0, 99);
    if (pick < 40)      r.pfx_len = bbe_pkg::LEN_W'($urandom_range(0, (len < 12) ? len : 12));
    else if (pick < 70) r.pfx_len = bbe_pkg::LEN_W'($urandom_range(0, len));
    else if (pick < 85) r.pfx_len = bbe_pkg::LEN_W'(len + $urandom_range(0, 1));
    else                r.pfx_len = bbe_pkg::LEN_W'($urandom_range(0, 2047));
    return r;
  endfunction

  // Wait until the driver has nothing left and every answer has come back.
  // Checked at the falling edge, where all clocked updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || start || answer_q.size() != 0);
  endtask

  // Length register write; only issued while the engine is idle.
  task automatic write_length(input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= bbe_pkg::LEN_W'(value);
    @(posedge clk);
    cfg_we     <= 1'b0;
    length_reg  = bbe_pkg::LEN_W'(value);
    phase_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests, holds each until the transfer edge.
  // Random gaps of about a quarter of the cycles, except for a stretch of
  // requests 500..799 where it runs back to back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic took;
    logic gaps_on;
    took    = start && (busy === 1'b0);
    gaps_on = !(sent_count >= 500 && sent_count < 800);
    if (took) begin
      predict_answer(cur_req);
      sent_count++;
    end
    // one assignment to start per edge: either a new request or a drop
    if (rst_n && (took || !start) && pending_q.size() != 0 &&
        !(gaps_on && $urandom_range(0, 99) < 24)) begin
      cur_req           = pending_q.pop_front();
      in_action        <= cur_req.action;
      in_first_set     <= cur_req.first_set;
      in_second_set    <= cur_req.second_set;
      in_bit_index     <= cur_req.bit_pos;
      in_prefix_length <= cur_req.pfx_len;
      start            <= 1'b1;
    end else if (took) begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobe is taken on its edge and matched to the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    if (out_strobe === 1'b1) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with nothing expected: status=%0b flag=%0b",
                 $time, out_status, out_flag);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        checked_count++;
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0b, got %0b", $time, want.status, out_status);
          fail_count++;
        end
        if (out_flag !== want.flag) begin
          $display("%0t: flag mismatch: expected %0b, got %0b", $time, want.flag, out_flag);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer in either direction.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int lengths [$];
    int len;
    int made;
    int k;
    int s;
    int i;
    length_reg = bbe_pkg::LEN_W'(bbe_pkg::MAX_BITS);
    for (s = 0; s < bbe_pkg::NUM_SETS; s++)
      for (i = 0; i < bbe_pkg::WORDS_PER_SET; i++) bank_words[s][i] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at the reset length of 1024: store starts empty.
    queue_request(bbe_pkg::ACT_TEST,   0, 0, 0, 0);       // empty after reset
    queue_request(bbe_pkg::ACT_SET,    0, 0, 0, 0);       // changes
    queue_request(bbe_pkg::ACT_SET,    0, 0, 0, 0);       // already set
    queue_request(bbe_pkg::ACT_SET,    7, 0, 1023, 0);    // top bit of top slot
    queue_request(bbe_pkg::ACT_TEST,   7, 0, 1023, 0);
    queue_request(bbe_pkg::ACT_TEST,   7, 0, 1022, 0);
    queue_request(bbe_pkg::ACT_PREFIX, 0, 0, 0, 0);       // empty prefix is full
    queue_request(bbe_pkg::ACT_PREFIX, 0, 0, 0, 1);
    queue_request(bbe_pkg::ACT_PREFIX, 0, 0, 0, 1024);
    queue_request(bbe_pkg::ACT_PREFIX, 0, 0, 0, 1025);    // longer than the set
    queue_request(bbe_pkg::ACT_PREFIX, 0, 0, 0, 2047);
    queue_request(bbe_pkg::ACT_UNION,  0, 7, 0, 0);       // brings in bit 1023
    queue_request(bbe_pkg::ACT_UNION,  0, 7, 0, 0);       // nothing new
    queue_request(bbe_pkg::ACT_DISJ,   0, 7, 0, 0);       // share bit 1023
    queue_request(bbe_pkg::ACT_DISJ,   1, 2, 0, 0);       // both empty
    queue_request(bbe_pkg::ACT_UNION,  5, 5, 0, 0);       // self merge
    queue_request(ACT_UNUSED_LO, 7, 7, 1023, 2047);
    queue_request(ACT_UNUSED_HI, 0, 0, 0, 0);
    queue_request(bbe_pkg::ACT_CLEAR,  0, 0, 0, 0);
    queue_request(bbe_pkg::ACT_TEST,   0, 0, 0, 0);
    wait_idle();

    // Short length: range errors, and bits past the length stay hidden.
    write_length(40);
    queue_request(bbe_pkg::ACT_SET,    3, 0, 39, 0);
    queue_request(bbe_pkg::ACT_SET,    3, 0, 40, 0);      // index at the length
    queue_request(bbe_pkg::ACT_TEST,   3, 0, 1023, 0);
    queue_request(bbe_pkg::ACT_PREFIX, 3, 0, 0, 41);
    queue_request(bbe_pkg::ACT_PREFIX, 3, 0, 0, 40);
    queue_request(bbe_pkg::ACT_UNION,  3, 7, 0, 0);       // bit 1023 of slot 7 is hidden
    queue_request(bbe_pkg::ACT_DISJ,   7, 7, 0, 0);
    wait_idle();

    // Extremes first (above capacity, zero, word boundaries), then random.
    lengths = '{2047, 0, 1, 63, 64, 65, 1024, 1023};
    for (i = 0; i < 8; i++)
      lengths.push_back(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                    : $urandom_range(1, 130));

    foreach (lengths[p]) begin
      write_length(lengths[p]);
      len  = live_length();
      made = 0;
      while (made < ITEMS_PER_PHASE) begin
        if (len > 0 && $urandom_range(0, 99) < 20) begin
          // fill a run of low bits in one slot, then ask about that prefix
          k = $urandom_range(1, (len < 24) ? len : 24);
          s = $urandom_range(0, 7);
          for (i = 0; i < k; i++) queue_request(bbe_pkg::ACT_SET, s, 0, i, 0);
          queue_request(bbe_pkg::ACT_PREFIX, s, 0, 0, k - 1 + $urandom_range(0, 2));
          made += k + 1;
        end else begin
          pending_q.push_back(random_request(len));
          made++;
        end
      end
      wait_idle();
    end

    // Watch for stray strobes once everything is in.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests over %0d length settings; %0d results checked",
             sent_count, phase_count, checked_count);
    $display("(%0d out of range, %0d with the flag set)", range_count, flag_count);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- bitset_bank_engine.f -----
hw/rtl/bbe_pkg.sv
hw/rtl/bitset_bank_engine.sv
tb/sv/testbench.sv
